[design/msv_pkg.sv]
// ----------------------------------------------------------------------------
// msv_pkg
// Types and constants shared by the monotone spline velocity block.
// ----------------------------------------------------------------------------
package msv_pkg;

   // Width of the wide product, numerator and divider datapath
   localparam int WIDE = 128;

   // Microseconds per second times three (Fritsch-Butland weight)
   localparam logic [31:0] US_SCALE = 32'd3000000;

   // Work handed from the front end to the back end, one per input that
   // produces results
   typedef struct packed {
      logic        compute;       // interior point, slope must be computed
      logic        neg;           // both position steps negative
      logic [31:0] h1;
      logic [31:0] h2;
      logic [31:0] m1;
      logic [31:0] m2;
      logic [31:0] velocity;      // value to emit when not computing
      logic        bad;
      logic        eot;
      logic        eor;
      logic        tail;          // last point: a second result follows
      logic [31:0] tail_velocity;
      logic        tail_bad;
   } job_type;

   // One result item
   typedef struct packed {
      logic [31:0] velocity;
      logic        bad_interval;
      logic        end_of_trajectory;
      logic        end_of_run;
   } rsp_type;

endpackage

[design/monotone_spline_velocity.sv]
// ----------------------------------------------------------------------------
// monotone_spline_velocity
// Fritsch-Butland monotone cubic slopes for one joint's trajectory points.
// ----------------------------------------------------------------------------
// Points are pushed in order; each result appears one point late, and the
// last point of a trajectory of two or more points releases two results.
// A first or last point passes its velocity straight through. An interior
// point whose steps agree in sign goes through seven shift-add multiplies
// in the back end, which build the numerator and denominator, then a
// 128-step restoring divider forms the rounded slope. A job queue lets the
// front accept points while the back end works, and a result queue holds
// finished results until they are popped.
module monotone_spline_velocity #(
   parameter int JOB_DEPTH = 2,
   parameter int RSP_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [31:0] req_time_us,
   input  logic [31:0] req_position,
   input  logic [31:0] req_velocity_in,
   input  logic        req_last_point,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_velocity,
   output logic        rsp_bad_interval,
   output logic        rsp_end_of_trajectory,
   output logic        rsp_end_of_run
);

   localparam int JW = $bits(msv_pkg::job_type);
   localparam int RW = $bits(msv_pkg::rsp_type);

   msv_pkg::job_type job_w, job_q;
   msv_pkg::rsp_type rsp_w, rsp_q;
   logic             accept, job_push, job_full, job_empty, job_pop;
   logic             out_push, out_full;

   // input transfer
   assign full   = job_full;
   assign accept = push && !job_full;

   msv_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .time_us     (req_time_us),
      .position    (req_position),
      .velocity_in (req_velocity_in),
      .last_point  (req_last_point),
      .job_push    (job_push),
      .job         (job_w)
   );

   msv_fifo #(.WIDTH(JW), .DEPTH(JOB_DEPTH)) u_job_q (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_w),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_q),
      .empty     (job_empty)
   );

   msv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_data  (job_q),
      .job_pop   (job_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (rsp_w)
   );

   msv_fifo #(.WIDTH(RW), .DEPTH(RSP_DEPTH)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (rsp_w),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (rsp_q),
      .empty     (empty)
   );

   // result ports
   assign rsp_velocity          = rsp_q.velocity;
   assign rsp_bad_interval      = rsp_q.bad_interval;
   assign rsp_end_of_trajectory = rsp_q.end_of_trajectory;
   assign rsp_end_of_run        = rsp_q.end_of_run;

endmodule

[design/msv_fifo.sv]
// ----------------------------------------------------------------------------
// msv_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module msv_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ff];

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

[design/msv_front.sv]
// ----------------------------------------------------------------------------
// msv_front
// Accepts trajectory points, keeps the two previous points and classifies
// each point into a job for the back end.
// ----------------------------------------------------------------------------
module msv_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [31:0]      time_us,
   input  logic [31:0]      position,
   input  logic [31:0]      velocity_in,
   input  logic             last_point,
   output logic             job_push,
   output msv_pkg::job_type job
);

   logic [31:0] prev_time_ff, prev_pos_ff, older_time_ff, older_pos_ff;
   logic [31:0] first_vel_ff;
   logic [1:0]  seen_ff, seen_in;
   logic        bad1, bad2, flat;
   logic [32:0] d1, d2, a1, a2;

   // step checks and position steps
   always_comb begin
      bad2 = !(time_us > prev_time_ff);
      bad1 = !(prev_time_ff > older_time_ff);
      d1   = {prev_pos_ff[31], prev_pos_ff} - {older_pos_ff[31], older_pos_ff};
      d2   = {position[31], position} - {prev_pos_ff[31], prev_pos_ff};
      a1   = d1[32] ? (33'd0 - d1) : d1;
      a2   = d2[32] ? (33'd0 - d2) : d2;
      flat = (d1 == '0) || (d2 == '0) || (d1[32] != d2[32]);
   end

   // job record
   always_comb begin
      job               = '0;
      job.h1            = prev_time_ff - older_time_ff;
      job.h2            = time_us - prev_time_ff;
      job.m1            = a1[31:0];
      job.m2            = a2[31:0];
      job.neg           = d1[32];
      job.tail          = last_point;
      job.tail_velocity = velocity_in;
      job.tail_bad      = bad2;
      job.eor           = !last_point;
      priority if (seen_ff == 2'd0) begin
         // single-point trajectory
         job.velocity = velocity_in;
         job.eot      = 1'b1;
         job.eor      = 1'b1;
         job.tail     = 1'b0;
      end else if (seen_ff == 2'd1) begin
         job.velocity = first_vel_ff;
         job.bad      = bad2;
      end else begin
         job.bad      = bad1 || bad2;
         job.compute  = !(bad1 || bad2) && !flat;
      end
   end

   assign job_push = accept && ((seen_ff != 2'd0) || last_point);

   // point history
   always_comb begin
      seen_in = seen_ff;
      if (accept) begin
         if (last_point) begin
            seen_in = 2'd0;
         end else begin
            seen_in = (seen_ff == 2'd0) ? 2'd1 : 2'd2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 2'd0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff  <= '0;
         prev_pos_ff   <= '0;
         older_time_ff <= '0;
         older_pos_ff  <= '0;
         first_vel_ff  <= '0;
      end else if (accept && !last_point) begin
         if (seen_ff == 2'd0) begin
            first_vel_ff <= velocity_in;
         end else begin
            older_time_ff <= prev_time_ff;
            older_pos_ff  <= prev_pos_ff;
         end
         prev_time_ff <= time_us;
         prev_pos_ff  <= position;
      end
   end

endmodule

[design/msv_back.sv]
// ----------------------------------------------------------------------------
// msv_back
// Carries out jobs: shift-add multiplier for the numerator and denominator,
// then a restoring divider, rounding and saturation; emits result items.
// ----------------------------------------------------------------------------
module msv_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_empty,
   input  msv_pkg::job_type job_data,
   output logic             job_pop,
   input  logic             out_full,
   output logic             out_push,
   output msv_pkg::rsp_type out_data
);

   localparam int W = msv_pkg::WIDE;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_EMIT = 3'd3;
   localparam logic [2:0] S_TAIL = 3'd4;

   // multiply steps
   localparam logic [2:0] OP_SCALE = 3'd0;  // 3e6 * (h1+h2)
   localparam logic [2:0] OP_NUM1  = 3'd1;  // * m1
   localparam logic [2:0] OP_NUM2  = 3'd2;  // * m2 -> numerator
   localparam logic [2:0] OP_DENA  = 3'd3;  // h1 * (h1+2h2)
   localparam logic [2:0] OP_DENB  = 3'd4;  // * m2 -> denominator
   localparam logic [2:0] OP_DENC  = 3'd5;  // h2 * (2h1+h2)
   localparam logic [2:0] OP_DEND  = 3'd6;  // * m1, added to denominator

   logic [2:0]       state_ff, state_in;
   logic [2:0]       op_ff, op_in;
   logic [5:0]       bit_ff, bit_in;
   logic [6:0]       step_ff, step_in;
   msv_pkg::job_type job_ff, job_in;
   logic [W-1:0]     a_ff, a_in, acc_ff, acc_in;
   logic [33:0]      b_ff, b_in;
   logic [W-1:0]     num_ff, num_in, den_ff, den_in, quo_ff, quo_in;
   logic [W:0]       rem_ff, rem_in;
   logic [31:0]      vel_ff, vel_in;
   logic [W-1:0]     prod, den_sum, q_next, lim;
   logic [W:0]       rem_sh;
   logic             ge;
   logic [31:0]      mag;
   logic [33:0]      sum_h, e1, e2;
   logic [2:0]       nop;

   // step operand sums
   always_comb begin
      sum_h = {2'b0, job_ff.h1} + {2'b0, job_ff.h2};
      e1    = {2'b0, job_ff.h1} + {1'b0, job_ff.h2, 1'b0};
      e2    = {1'b0, job_ff.h1, 1'b0} + {2'b0, job_ff.h2};
   end

   // one multiply step and one divide step
   always_comb begin
      prod    = acc_ff + (b_ff[0] ? a_ff : '0);
      den_sum = den_ff + prod;
      rem_sh  = {rem_ff[W-1:0], quo_ff[W-1]};
      ge      = (rem_sh >= {1'b0, den_ff});
      q_next  = {quo_ff[W-2:0], ge};
      lim     = job_ff.neg ? W'(33'h080000000) : W'(33'h07FFFFFFF);
      mag     = (q_next > lim) ? lim[31:0] : q_next[31:0];
      nop     = op_ff + 1'b1;
   end

   assign job_pop  = (state_ff == S_IDLE) && !job_empty;
   assign out_push = ((state_ff == S_EMIT) || (state_ff == S_TAIL)) && !out_full;

   always_comb begin
      if (state_ff == S_TAIL) begin
         out_data = {job_ff.tail_velocity, job_ff.tail_bad, 1'b1, 1'b1};
      end else begin
         out_data = {vel_ff, job_ff.bad, job_ff.eot, job_ff.eor};
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      bit_in   = bit_ff;
      step_in  = step_ff;
      job_in   = job_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      vel_in   = vel_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!job_empty) begin
               job_in = job_data;
               vel_in = job_data.velocity;
               op_in  = OP_SCALE;
               bit_in = '0;
               acc_in = '0;
               a_in   = W'(msv_pkg::US_SCALE);
               b_in   = {2'b0, job_data.h1} + {2'b0, job_data.h2};
               state_in = job_data.compute ? S_MUL : S_EMIT;
            end
         end
         S_MUL: begin
            acc_in = prod;
            a_in   = {a_ff[W-2:0], 1'b0};
            b_in   = {1'b0, b_ff[33:1]};
            bit_in = bit_ff + 1'b1;
            if (bit_ff == 6'd33) begin
               bit_in = '0;
               acc_in = '0;
               op_in  = nop;
               if (op_ff == OP_NUM2) begin
                  num_in = prod;
               end else if (op_ff == OP_DENB) begin
                  den_in = prod;
               end
               // next operands
               unique case (nop)
                  OP_NUM1: begin a_in = prod;            b_in = {2'b0, job_ff.m1}; end
                  OP_NUM2: begin a_in = prod;            b_in = {2'b0, job_ff.m2}; end
                  OP_DENA: begin a_in = W'(job_ff.h1);   b_in = e1;                end
                  OP_DENB: begin a_in = prod;            b_in = {2'b0, job_ff.m2}; end
                  OP_DENC: begin a_in = W'(job_ff.h2);   b_in = e2;                end
                  OP_DEND: begin a_in = prod;            b_in = {2'b0, job_ff.m1}; end
                  default: begin a_in = '0;              b_in = sum_h;             end
               endcase
               if (op_ff == OP_DEND) begin
                  // divide (2 num + den) by 2 den for round-half-away
                  quo_in   = {num_ff[W-2:0], 1'b0} + den_sum;
                  den_in   = {den_sum[W-2:0], 1'b0};
                  rem_in   = '0;
                  step_in  = '0;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            rem_in  = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
            quo_in  = q_next;
            step_in = step_ff + 1'b1;
            if (step_ff == 7'(W - 1)) begin
               vel_in   = job_ff.neg ? (32'd0 - mag) : mag;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!out_full) begin
               state_in = job_ff.tail ? S_TAIL : S_IDLE;
            end
         end
         S_TAIL: begin
            if (!out_full) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      bit_ff  <= bit_in;
      step_ff <= step_in;
      job_ff  <= job_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      vel_ff  <= vel_in;
   end

endmodule
